// ----- hdl/twcs_pkg.sv -----
`default_nettype none
package twcs_pkg;

    // Texture and window geometry
    localparam int TEX_H     = 64;
    localparam int WIN_H     = 512;
    localparam int FRAC_BITS = 16;

    // Widths of the stored values
    localparam int POS_W   = 32;
    localparam int ROW_W   = 10;
    localparam int LH_W    = 16;
    localparam int COL_W   = 6;
    localparam int TEX_W   = 3;
    localparam int OFF_W   = 12;
    localparam int TEXR_W  = $clog2(TEX_H);
    localparam int DIV_W   = $clog2(TEX_H + 1) + FRAC_BITS;
    localparam int CNT_W   = $clog2(DIV_W);
    localparam int BASE_W  = 18;

    // Input item kinds
    localparam logic KIND_SETUP = 1'b0;
    localparam logic KIND_ROW   = 1'b1;

    // Ray sign codes
    localparam logic [1:0] SIGN_POS = 2'd1;
    localparam logic [1:0] SIGN_NEG = 2'd2;

    // Face textures
    localparam logic [TEX_W-1:0] TEX_Y_POS = 3'd4;
    localparam logic [TEX_W-1:0] TEX_Y_NEG = 3'd2;
    localparam logic [TEX_W-1:0] TEX_X_NEG = 3'd5;
    localparam logic [TEX_W-1:0] TEX_X_POS = 3'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic setup_load;
        logic div_step;
        logic mul_load;
        logic row_emit;
        logic out_take;
    } t_twcs_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic div_last;
        logic span_active;
        logic out_full;
    } t_twcs_stat;

endpackage
`default_nettype wire

// ----- hdl/twcs_ctrl.sv -----
`default_nettype none
module twcs_ctrl import twcs_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    input  wire logic       i_kind,
    input  wire logic       i_m_tready,
    input  wire t_twcs_stat i_stat,
    output logic            o_s_tready,
    output t_twcs_cmd       o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    // Take items only while idle and the output slot frees up
    assign o_s_tready = (r_state == ST_IDLE) && (!i_stat.out_full || i_m_tready);
    assign w_accept   = i_s_tvalid && o_s_tready;

    // Decode commands
    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.out_take   = i_stat.out_full && i_m_tready;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_kind == KIND_SETUP)) begin
                    o_cmd.setup_load = 1'b1;
                    n_state          = ST_DIV;
                end else if (w_accept && (i_kind == KIND_ROW)) begin
                    o_cmd.row_emit = i_stat.span_active;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul_load = 1'b1;
                n_state        = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/twcs_dpath.sv -----
`default_nettype none
module twcs_dpath import twcs_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_twcs_cmd         i_cmd,
    input  wire logic              i_wall_side,
    input  wire logic [1:0]        i_ray_x_sign,
    input  wire logic [1:0]        i_ray_y_sign,
    input  wire logic [TEX_W-1:0]  i_default_texture,
    input  wire logic [COL_W-1:0]  i_texel_column,
    input  wire logic [LH_W-1:0]   i_line_height,
    input  wire logic [8:0]        i_draw_start,
    input  wire logic [ROW_W-1:0]  i_draw_end,
    output t_twcs_stat             o_stat,
    output logic [8:0]             o_screen_row,
    output logic [TEX_W-1:0]       o_texture_select,
    output logic [OFF_W-1:0]       o_texel_offset,
    output logic                   o_last_row
);

    localparam logic [DIV_W-1:0] DIVIDEND = DIV_W'(TEX_H) << FRAC_BITS;

    logic [LH_W-1:0]          r_div;
    logic [LH_W-1:0]          r_rem;
    logic [DIV_W-1:0]         r_quot;
    logic [CNT_W-1:0]         r_cnt;
    logic [BASE_W-1:0]        r_base;
    logic [POS_W-1:0]         r_step;
    logic [POS_W-1:0]         r_pos;
    logic [ROW_W-1:0]         r_cur;
    logic [ROW_W-1:0]         r_end;
    logic [COL_W-1:0]         r_col;
    logic [TEX_W-1:0]         r_tex;
    logic                     r_out_valid;

    logic [LH_W-1:0]          w_lh;
    logic [TEX_W-1:0]         w_face;
    logic [LH_W:0]            w_trial;
    logic                     w_ge;
    logic signed [BASE_W+DIV_W:0] w_prod;
    logic [POS_W-1:0]         w_neg;
    logic [POS_W-1:0]         w_mag;
    logic [POS_W-1:0]         w_ip;
    logic [TEXR_W-1:0]        w_ty;
    logic [ROW_W-1:0]         w_cur_inc;

    // Zero height counts as one
    assign w_lh = (i_line_height == '0) ? LH_W'(1) : i_line_height;

    // Pick the face texture
    always_comb begin
        w_face = i_default_texture;
        if (i_wall_side) begin
            if (i_ray_y_sign == SIGN_POS) begin
                w_face = TEX_Y_POS;
            end else if (i_ray_y_sign == SIGN_NEG) begin
                w_face = TEX_Y_NEG;
            end
        end else begin
            if (i_ray_x_sign == SIGN_NEG) begin
                w_face = TEX_X_NEG;
            end else if (i_ray_x_sign == SIGN_POS) begin
                w_face = TEX_X_POS;
            end
        end
    end

    // One restoring division step per cycle
    assign w_trial = {r_rem, DIVIDEND[r_cnt]};
    assign w_ge    = w_trial >= {1'b0, r_div};

    // Start position, wraps to the position width
    assign w_prod = $signed(r_base) * $signed({1'b0, r_quot});

    // Texel row: position truncated toward zero, masked
    assign w_neg     = '0 - r_pos;
    assign w_mag     = w_neg >> FRAC_BITS;
    assign w_ip      = r_pos[POS_W-1] ? ('0 - w_mag) : (r_pos >> FRAC_BITS);
    assign w_ty      = w_ip[TEXR_W-1:0];
    assign w_cur_inc = r_cur + ROW_W'(1);

    assign o_stat.div_last    = (r_cnt == '0);
    assign o_stat.span_active = (r_cur < r_end);
    assign o_stat.out_full    = r_out_valid;

    // Column state, divider and position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_pos  <= '0;
            r_cur  <= '0;
            r_end  <= '0;
            r_col  <= '0;
            r_tex  <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_cmd.setup_load) begin
                r_div  <= w_lh;
                r_rem  <= '0;
                r_quot <= '0;
                r_cnt  <= CNT_W'(DIV_W - 1);
                r_base <= BASE_W'(i_draw_start) + BASE_W'(w_lh >> 1)
                          - BASE_W'(WIN_H / 2);
                r_col  <= i_texel_column;
                r_tex  <= w_face;
                r_cur  <= ROW_W'(i_draw_start);
                r_end  <= (i_draw_end > ROW_W'(WIN_H)) ? ROW_W'(WIN_H) : i_draw_end;
            end
            if (i_cmd.div_step) begin
                r_rem  <= w_ge ? LH_W'(w_trial - {1'b0, r_div}) : w_trial[LH_W-1:0];
                r_quot <= {r_quot[DIV_W-2:0], w_ge};
                if (r_cnt != '0) begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
            if (i_cmd.mul_load) begin
                r_step <= POS_W'(r_quot);
                r_pos  <= w_prod[POS_W-1:0];
            end
            if (i_cmd.row_emit) begin
                r_pos <= r_pos + r_step;
                r_cur <= w_cur_inc;
            end
        end
    end

    // Output slot valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.row_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_cmd.out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load the pixel result
    always_ff @(posedge i_clk) begin
        if (i_cmd.row_emit) begin
            o_screen_row     <= r_cur[8:0];
            o_texture_select <= r_tex;
            o_texel_offset   <= OFF_W'(w_ty) * OFF_W'(TEX_H) + OFF_W'(r_col);
            o_last_row       <= (w_cur_inc == r_end);
        end
    end

endmodule
`default_nettype wire

// ----- hdl/textured_wall_column_stepper.sv -----
// Channel   Dir  Signals                         Contents
// s         in   i_s_tvalid/o_s_tready           tuser: kind; tdata: set-up fields
// m         out  o_m_tvalid/i_m_tready           tdata: pixel fields; tlast: last_row
//
// Rows stream one per cycle through the output register unless the output stalls.
// A set-up item holds off the input while it is loaded, the restoring divider makes one
// quotient bit per cycle, and then the start-position multiply is done.
// Reset (synchronous, active low) leaves an empty span, so row items give no pixel.
// A stalled output keeps its pixel; a new row is taken in the cycle it is read out.
`default_nettype none
module textured_wall_column_stepper import twcs_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // [0] wall_side, [2:1] ray_x_sign, [4:3] ray_y_sign, [7:5] default_texture,
    // [13:8] texel_column, [29:14] line_height, [38:30] draw_start,
    // [48:39] draw_end, [55:49] zero
    input  wire logic [55:0] i_s_tdata,
    // [0] kind
    input  wire logic        i_s_tuser,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [8:0] screen_row, [11:9] texture_select, [23:12] texel_offset
    output logic [23:0]      o_m_tdata,
    output logic             o_m_tlast
);

    t_twcs_cmd  w_cmd;
    t_twcs_stat w_stat;
    logic [8:0]       w_row;
    logic [TEX_W-1:0] w_tex;
    logic [OFF_W-1:0] w_off;

    twcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_kind     (i_s_tuser),
        .i_m_tready (i_m_tready),
        .i_stat     (w_stat),
        .o_s_tready (o_s_tready),
        .o_cmd      (w_cmd)
    );

    twcs_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_wall_side       (i_s_tdata[0]),
        .i_ray_x_sign      (i_s_tdata[2:1]),
        .i_ray_y_sign      (i_s_tdata[4:3]),
        .i_default_texture (i_s_tdata[7:5]),
        .i_texel_column    (i_s_tdata[13:8]),
        .i_line_height     (i_s_tdata[29:14]),
        .i_draw_start      (i_s_tdata[38:30]),
        .i_draw_end        (i_s_tdata[48:39]),
        .o_stat            (w_stat),
        .o_screen_row      (w_row),
        .o_texture_select  (w_tex),
        .o_texel_offset    (w_off),
        .o_last_row        (o_m_tlast)
    );

    assign o_m_tvalid = w_stat.out_full;
    assign o_m_tdata  = {w_off, w_tex, w_row};

    // A pixel is made only inside the span
    a_emit_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.row_emit |-> w_stat.span_active)
        else $error("row emitted outside span");

    // A new pixel never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.row_emit |-> (!w_stat.out_full || i_m_tready))
        else $error("pixel overwritten");

    // The divider holds off input after a set-up
    a_setup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.setup_load |=> !o_s_tready)
        else $error("input taken during division");

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import twcs_pkg::*;

    // Wall side and ray sign codes not named in the package
    localparam logic       SIDE_VERT   = 1'b0;
    localparam logic       SIDE_HORIZ  = 1'b1;
    localparam logic [1:0] SIGN_ZERO   = 2'd0;
    localparam logic [1:0] SIGN_UNUSED = 2'd3;

    localparam int ITEM_TARGET = 1750;
    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 60;

    typedef struct {
        logic             kind;
        logic             side;
        logic [1:0]       x_sign;
        logic [1:0]       y_sign;
        logic [TEX_W-1:0] dflt_tex;
        logic [COL_W-1:0] column;
        logic [LH_W-1:0]  height;
        logic [8:0]       row_first;
        logic [ROW_W-1:0] row_stop;
        bit               drain_mark;
    } t_column_item;

    typedef struct {
        logic [8:0]       row;
        logic [TEX_W-1:0] tex;
        logic [OFF_W-1:0] offset;
        logic             last;
    } t_pixel;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [55:0] i_s_tdata = '0;
    logic        i_s_tuser = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [23:0] o_m_tdata;
    logic        o_m_tlast;

    textured_wall_column_stepper u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // Column state mirrored from the block, cleared as after reset
    logic [POS_W-1:0] col_step = '0;
    logic [POS_W-1:0] col_pos = '0;
    logic [ROW_W-1:0] col_row = '0;
    logic [ROW_W-1:0] col_end = '0;
    logic [COL_W-1:0] col_texel = '0;
    logic [TEX_W-1:0] col_tex = '0;

    t_column_item items_to_send[$];
    t_pixel       pixels_due[$];
    t_column_item offered;
    bit           load_next;
    bit           draining = 1'b0;
    int           cycle_cnt = 0;
    int           stall_left = 0;
    int           pixels_checked = 0;
    int           setups_sent = 0;
    int           rows_sent = 0;
    int           fail_count = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // Random gap on either side, none inside the quiet window
    function automatic bit take_gap();
        if (cycle_cnt >= 2000 && cycle_cnt < 3500)
            return 1'b0;
        return $urandom_range(99) < 20;
    endfunction

    // Apply one accepted item to the column state and queue its pixel
    function automatic void step_column(t_column_item it);
        logic [31:0] lh;
        logic [63:0] quot;
        longint      base;
        longint      prod;
        logic [31:0] mag;
        logic [31:0] whole;
        t_pixel      px;
        if (it.kind == KIND_SETUP) begin
            setups_sent++;
            lh = (it.height == '0) ? 32'd1 : 32'(it.height);
            quot = (64'(TEX_H) << FRAC_BITS) / 64'(lh);
            if (quot > 64'hFFFF_FFFF)
                quot = 64'hFFFF_FFFF;
            col_step = quot[31:0];
            base = longint'(it.row_first) - longint'(WIN_H / 2) + longint'(lh / 2);
            prod = base * longint'(quot);
            col_pos = prod[31:0];
            col_texel = it.column;
            col_tex = it.dflt_tex;
            if (it.side == SIDE_HORIZ) begin
                if (it.y_sign == SIGN_POS)
                    col_tex = TEX_Y_POS;
                else if (it.y_sign == SIGN_NEG)
                    col_tex = TEX_Y_NEG;
            end else begin
                if (it.x_sign == SIGN_NEG)
                    col_tex = TEX_X_NEG;
                else if (it.x_sign == SIGN_POS)
                    col_tex = TEX_X_POS;
            end
            col_row = ROW_W'(it.row_first);
            col_end = (it.row_stop > ROW_W'(WIN_H)) ? ROW_W'(WIN_H) : it.row_stop;
            return;
        end
        rows_sent++;
        // Span finished: nothing changes
        if (col_row >= col_end)
            return;
        // Truncate toward zero, then keep the low bits of the texel row
        if (col_pos[31]) begin
            mag = (32'd0 - col_pos) >> FRAC_BITS;
            whole = 32'd0 - mag;
        end else begin
            whole = col_pos >> FRAC_BITS;
        end
        px.row = col_row[8:0];
        px.tex = col_tex;
        px.offset = OFF_W'(TEX_H * (whole & (TEX_H - 1)) + col_texel);
        px.last = (col_row + 1'b1 == col_end);
        pixels_due.push_back(px);
        col_pos = col_pos + col_step;
        col_row = col_row + 1'b1;
    endfunction

    // Sender: hold an offered item until the transfer, then load the next
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                step_column(offered);
            if (!(i_s_tvalid && !o_s_tready)) begin
                load_next = 1'b0;
                if (draining && pixels_due.size() == 0)
                    draining = 1'b0;
                if (!draining && items_to_send.size() != 0 && !take_gap()) begin
                    if (items_to_send[0].drain_mark) begin
                        items_to_send.delete(0);
                        draining = 1'b1;
                    end else begin
                        offered = items_to_send.pop_front();
                        load_next = 1'b1;
                        i_s_tdata <= {7'd0, offered.row_stop, offered.row_first,
                                      offered.height, offered.column, offered.dflt_tex,
                                      offered.y_sign, offered.x_sign, offered.side};
                        i_s_tuser <= offered.kind;
                    end
                end
                i_s_tvalid <= load_next;
            end
        end
    end

    // Receiver: check each pixel transfer against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pixels_due.size() == 0) begin
                $error("unexpected pixel: tdata %h tlast %b", o_m_tdata, o_m_tlast);
                fail_count++;
            end else begin
                if (o_m_tdata[8:0] !== pixels_due[0].row) begin
                    $error("screen_row: expected %0d, got %0d",
                           pixels_due[0].row, o_m_tdata[8:0]);
                    fail_count++;
                end
                if (o_m_tdata[11:9] !== pixels_due[0].tex) begin
                    $error("texture_select: expected %0d, got %0d",
                           pixels_due[0].tex, o_m_tdata[11:9]);
                    fail_count++;
                end
                if (o_m_tdata[23:12] !== pixels_due[0].offset) begin
                    $error("texel_offset: expected %0d, got %0d",
                           pixels_due[0].offset, o_m_tdata[23:12]);
                    fail_count++;
                end
                if (o_m_tlast !== pixels_due[0].last) begin
                    $error("last_row: expected %0b, got %0b",
                           pixels_due[0].last, o_m_tlast);
                    fail_count++;
                end
                pixels_due.delete(0);
            end
            pixels_checked++;
            // Hold off once so the output backs up into the input
            if (pixels_checked == HOLD_AT)
                stall_left = HOLD_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= !take_gap();
        end
    end

    function automatic t_column_item make_setup(logic side, logic [1:0] xs, logic [1:0] ys,
                                                logic [2:0] dtex, logic [5:0] col,
                                                logic [15:0] lh, logic [8:0] ds,
                                                logic [9:0] de);
        t_column_item it;
        it.kind = KIND_SETUP;
        it.side = side;
        it.x_sign = xs;
        it.y_sign = ys;
        it.dflt_tex = dtex;
        it.column = col;
        it.height = lh;
        it.row_first = ds;
        it.row_stop = de;
        it.drain_mark = 1'b0;
        return it;
    endfunction

    // Row items carry random leftovers in the unused fields
    task automatic queue_rows(int count);
        t_column_item it;
        repeat (count) begin
            it = make_setup(1'($urandom_range(1)), 2'($urandom_range(3)),
                            2'($urandom_range(3)), 3'($urandom_range(7)),
                            6'($urandom_range(63)), 16'($urandom_range(65535)),
                            9'($urandom_range(511)), 10'($urandom_range(1023)));
            it.kind = KIND_ROW;
            items_to_send.push_back(it);
        end
    endtask

    initial begin
        t_column_item it;
        int queued;
        int stop;
        int span;
        int pick;
        logic [15:0] lh;
        logic [8:0]  ds;

        // Directed: row before any set-up, extremes and every face rule
        queue_rows(1);
        items_to_send.push_back(make_setup(SIDE_VERT, SIGN_NEG, SIGN_ZERO, 3'd1, 6'd0,
                                           16'd0, 9'd0, 10'd3));
        queue_rows(4);
        items_to_send.push_back(make_setup(SIDE_HORIZ, SIGN_POS, SIGN_POS, 3'd7, 6'd63,
                                           16'hFFFF, 9'd511, 10'd1023));
        queue_rows(2);
        items_to_send.push_back(make_setup(SIDE_HORIZ, SIGN_ZERO, SIGN_NEG, 3'd6, 6'd21,
                                           16'd1, 9'd100, 10'd103));
        queue_rows(3);
        items_to_send.push_back(make_setup(SIDE_VERT, SIGN_POS, SIGN_UNUSED, 3'd2, 6'd42,
                                           16'd300, 9'd200, 10'd200));
        queue_rows(1);
        items_to_send.push_back(make_setup(SIDE_VERT, SIGN_UNUSED, SIGN_POS, 3'd5, 6'd7,
                                           16'd77, 9'd250, 10'd252));
        queue_rows(2);
        items_to_send.push_back(make_setup(SIDE_HORIZ, SIGN_NEG, SIGN_UNUSED, 3'd0, 6'd9,
                                           16'd2, 9'd0, 10'd2));
        queue_rows(2);
        queued = items_to_send.size();

        // Let every directed pixel come back before the random columns
        it = make_setup(SIDE_VERT, SIGN_ZERO, SIGN_ZERO, 3'd0, 6'd0, 16'd1, 9'd0, 10'd0);
        it.drain_mark = 1'b1;
        items_to_send.push_back(it);

        // Random columns: mostly short spans, some empty, cut short or past the window
        while (queued < ITEM_TARGET) begin
            pick = $urandom_range(9);
            if (pick == 0)
                lh = ($urandom_range(2) == 0) ? 16'd0 :
                     ($urandom_range(1) == 0) ? 16'd1 : 16'hFFFF;
            else if (pick < 6)
                lh = 16'($urandom_range(1, 600));
            else
                lh = 16'($urandom_range(65535));
            ds = 9'($urandom_range(511));
            pick = $urandom_range(19);
            if (pick == 0) begin
                stop = $urandom_range(0, ds);
            end else if (pick == 1) begin
                ds = 9'($urandom_range(440, 511));
                stop = $urandom_range(WIN_H, 1023);
            end else if (pick == 2) begin
                stop = ds + $urandom_range(1, 300);
            end else begin
                stop = ds + $urandom_range(1, 24);
            end
            it = make_setup(1'($urandom_range(1)), 2'($urandom_range(3)),
                            2'($urandom_range(3)), 3'($urandom_range(7)),
                            6'($urandom_range(63)), lh, ds, 10'(stop));
            items_to_send.push_back(it);
            span = ((stop > WIN_H) ? WIN_H : stop) - ds;
            if (span < 0)
                span = 0;
            if ($urandom_range(9) == 0)
                span = $urandom_range(0, span);
            else
                span = span + $urandom_range(0, 2);
            queue_rows(span);
            queued += span + 1;
            // Now and then let the sender wait for every pixel to come back
            if ($urandom_range(29) == 0) begin
                it.drain_mark = 1'b1;
                items_to_send.push_back(it);
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the last transfer in, then for every pixel out
        do @(negedge i_clk);
        while (items_to_send.size() != 0 || i_s_tvalid || draining);
        while (pixels_due.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        if (pixels_due.size() != 0) begin
            $error("%0d predicted pixels never arrived", pixels_due.size());
            fail_count++;
        end
        $display("Run covered %0d column set-ups and %0d row advances,", setups_sent,
                 rows_sent);
        $display("with %0d pixels compared field by field.", pixels_checked);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire
